// ===== src/shma_pkg.sv =====
// Shared constants, codes and types for the stack and heap word allocator.
package shma_pkg;

	// Default size of the word store
	localparam int unsigned MEM_WORDS_DEF = 1024;

	// Payload widths of the request and result transactions
	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned ADDR_W  = $clog2(MEM_WORDS_DEF);
	localparam int unsigned DEPTH_W = ADDR_W + 1;
	localparam int unsigned ERR_W   = 3;

	// Width of the internal signed arithmetic on words, links and sizes
	localparam int unsigned CALC_W = 34;

	typedef logic signed [CALC_W-1:0] calc_t;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd4;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_STK_FULL  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_STK_EMPTY = 3'd2;
	localparam logic [ERR_W-1:0] ERR_HEAP_FULL = 3'd3;
	localparam logic [ERR_W-1:0] ERR_BAD_COUNT = 3'd4;
	localparam logic [ERR_W-1:0] ERR_BAD_FREE  = 3'd5;

	// Link address of the head block and the end-of-chain mark
	localparam int ROOT_LINK = 2;
	localparam calc_t LINK_END = -34'sd1;

	// Sign-extend a stored word into the arithmetic width
	function automatic calc_t sext(input logic [WORD_W-1:0] w);
		sext = {{(CALC_W-WORD_W){w[WORD_W-1]}}, w};
	endfunction

endpackage

// ===== src/shma_req_if.sv =====
// Request channel: operation and its operands.
interface shma_req_if;
	logic                          valid;
	logic                          ready;
	logic [shma_pkg::FUNC_W-1:0]   func;
	logic signed [shma_pkg::WORD_W-1:0] push_value;
	logic [shma_pkg::COUNT_W-1:0]  alloc_words;
	logic [shma_pkg::ADDR_W-1:0]   free_address;

	modport source(output valid, func, push_value, alloc_words, free_address, input ready);
	modport sink(input valid, func, push_value, alloc_words, free_address, output ready);
endinterface

// ===== src/shma_rsp_if.sv =====
// Result channel: read word, block address, stack depth and error code.
interface shma_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [shma_pkg::WORD_W-1:0] read_word;
	logic [shma_pkg::ADDR_W-1:0]        block_address;
	logic [shma_pkg::DEPTH_W-1:0]       stack_depth;
	logic [shma_pkg::ERR_W-1:0]         error_code;

	modport source(output valid, read_word, block_address, stack_depth, error_code, input ready);
	modport sink(input valid, read_word, block_address, stack_depth, error_code, output ready);
endinterface

// ===== src/shma_ram.sv =====
// Single-port word store with registered read data.
module shma_ram #(
	parameter int unsigned DEPTH = shma_pkg::MEM_WORDS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        we,
	input  logic [AW-1:0]               addr,
	input  logic [shma_pkg::WORD_W-1:0] wdata,
	output logic [shma_pkg::WORD_W-1:0] rdata
);

	logic [shma_pkg::WORD_W-1:0] mem [DEPTH];

	// Write or read one word per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== src/stack_heap_memory_allocator.sv =====
// Push and requests rejected up front go from the execute state to the done state; pop, peek
// and free first wait for one memory read. The next request is taken back in the idle state.
// Allocate runs two walks of the block chain (check, then commit), merging free neighbours;
// the commit walk writes back the header of each block moved past, then the new block headers.
// One transaction is worked on at a time; a finished result waits in the output register.
// Reset (arst_n low) clears the control state; an init pass then writes the head block
// header (0, 0, -1) before the first request is taken.
module stack_heap_memory_allocator #(
	parameter int unsigned MEM_WORDS = shma_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	shma_req_if.sink       req,
	shma_rsp_if.source     rsp
);

	localparam int unsigned AW     = $clog2(MEM_WORDS);
	localparam int unsigned PW     = AW + 1;
	localparam int unsigned LIMIT  = 2 * MEM_WORDS + 8;
	localparam int unsigned NW     = $clog2(LIMIT + 1);

	// Sequencer states
	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_EXEC    = 4'd2;
	localparam logic [3:0] S_POP_WT  = 4'd3;
	localparam logic [3:0] S_FREE_WT = 4'd4;
	localparam logic [3:0] S_RD      = 4'd5;
	localparam logic [3:0] S_EVAL    = 4'd6;
	localparam logic [3:0] S_STEP    = 4'd7;
	localparam logic [3:0] S_WR      = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	// Header write lists
	localparam logic [1:0] L_MOVE = 2'd0;
	localparam logic [1:0] L_END  = 2'd1;
	localparam logic [1:0] L_FIT  = 2'd2;
	localparam logic [1:0] L_APP  = 2'd3;

	logic [3:0] state_q;
	logic [1:0] init_q;
	logic [1:0] ph_q;
	logic [1:0] list_q;
	logic [2:0] wstep_q;
	logic       pass_q;
	logic       first_q;
	logic [NW-1:0] n_q;

	logic [shma_pkg::FUNC_W-1:0]  func_q;
	logic [shma_pkg::WORD_W-1:0]  pv_q;
	logic [shma_pkg::COUNT_W-1:0] need_q;
	logic [shma_pkg::ADDR_W-1:0]  fa_q;

	logic [PW-1:0] sp_q;
	logic [PW-1:0] ht_q;

	shma_pkg::calc_t cur_q, sz_q, lnk_q, used_q, u2_q, s2_q, l2_q;

	logic [shma_pkg::WORD_W-1:0]  res_word_q;
	logic [shma_pkg::ADDR_W-1:0]  res_addr_q;
	logic [shma_pkg::ERR_W-1:0]   res_err_q;

	logic                          out_valid_q;
	logic [shma_pkg::WORD_W-1:0]   out_word_q;
	logic [shma_pkg::ADDR_W-1:0]   out_addr_q;
	logic [shma_pkg::DEPTH_W-1:0]  out_depth_q;
	logic [shma_pkg::ERR_W-1:0]    out_err_q;

	// Memory port
	logic                         mem_en, mem_we, mem_ok, oor_q;
	shma_pkg::calc_t              mem_addr;
	logic [shma_pkg::WORD_W-1:0]  mem_wdata, ram_rdata;
	shma_pkg::calc_t              rdv;

	// Derived values
	shma_pkg::calc_t need_c, sp_c, ht_c, fa_c, rd_base, nb_fit, nb_app;
	logic            fit, brk, app_bad, list_last;
	shma_pkg::calc_t wl_addr;
	logic [shma_pkg::WORD_W-1:0] wl_data;

	assign need_c  = shma_pkg::calc_t'({1'b0, need_q});
	assign sp_c    = shma_pkg::calc_t'({1'b0, sp_q});
	assign ht_c    = shma_pkg::calc_t'({1'b0, ht_q});
	assign fa_c    = shma_pkg::calc_t'({1'b0, fa_q});
	assign rd_base = first_q ? shma_pkg::calc_t'(shma_pkg::ROOT_LINK) : lnk_q;
	assign nb_fit  = cur_q + need_c + 34'sd1;
	assign nb_app  = cur_q + sz_q + 34'sd1;
	assign fit     = (used_q == 34'sd0) && ((sz_q == need_c) || (sz_q >= need_c + 34'sd3));
	assign brk     = (lnk_q == shma_pkg::LINK_END) || fit;
	assign app_bad = !fit && ((lnk_q != shma_pkg::LINK_END) || (nb_app < 34'sd0) ||
		!(nb_app + 34'sd2 + need_c < sp_c));
	assign rdv     = oor_q ? 34'sd0 : shma_pkg::sext(ram_rdata);
	assign mem_ok  = (mem_addr >= 34'sd0) && (mem_addr < shma_pkg::calc_t'(MEM_WORDS));

	// Select the header write for the current list step
	always_comb begin
		wl_addr   = cur_q;
		wl_data   = '0;
		list_last = 1'b0;
		case (list_q)
			L_MOVE, L_END: begin
				if (wstep_q == 3'd0) begin
					wl_addr = cur_q - 34'sd1;
					wl_data = sz_q[shma_pkg::WORD_W-1:0];
				end else begin
					wl_addr   = cur_q;
					wl_data   = lnk_q[shma_pkg::WORD_W-1:0];
					list_last = 1'b1;
				end
			end
			L_FIT: begin
				case (wstep_q)
					3'd0: begin
						wl_addr   = cur_q - 34'sd2;
						wl_data   = 32'd1;
						list_last = (sz_q == need_c);
					end
					3'd1: begin
						wl_addr = nb_fit;
						wl_data = '0;
					end
					3'd2: begin
						wl_addr = nb_fit + 34'sd1;
						wl_data = shma_pkg::WORD_W'(sz_q - need_c - 34'sd3);
					end
					3'd3: begin
						wl_addr = cur_q - 34'sd1;
						wl_data = shma_pkg::WORD_W'(need_c);
					end
					3'd4: begin
						wl_addr = nb_fit + 34'sd2;
						wl_data = lnk_q[shma_pkg::WORD_W-1:0];
					end
					default: begin
						wl_addr   = cur_q;
						wl_data   = shma_pkg::WORD_W'(nb_fit + 34'sd2);
						list_last = 1'b1;
					end
				endcase
			end
			default: begin
				case (wstep_q)
					3'd0: begin
						wl_addr = nb_app;
						wl_data = 32'd1;
					end
					3'd1: begin
						wl_addr = nb_app + 34'sd1;
						wl_data = shma_pkg::WORD_W'(need_c);
					end
					3'd2: begin
						wl_addr = cur_q;
						wl_data = shma_pkg::WORD_W'(nb_app + 34'sd2);
					end
					default: begin
						wl_addr   = nb_app + 34'sd2;
						wl_data   = '1;
						list_last = 1'b1;
					end
				endcase
			end
		endcase
	end

	// Drive the memory port from the sequencer state
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_INIT: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = shma_pkg::calc_t'({1'b0, init_q});
				mem_wdata = (init_q == 2'd2) ? '1 : '0;
			end
			S_EXEC: begin
				case (func_q)
					shma_pkg::FUNC_PUSH: begin
						mem_en    = sp_q > ht_q + PW'(1);
						mem_we    = 1'b1;
						mem_addr  = sp_c - 34'sd1;
						mem_wdata = pv_q;
					end
					shma_pkg::FUNC_POP, shma_pkg::FUNC_PEEK: begin
						mem_en   = 1'b1;
						mem_addr = sp_c;
					end
					shma_pkg::FUNC_FREE: begin
						mem_en   = 1'b1;
						mem_addr = fa_c - 34'sd3;
					end
					default: ;
				endcase
			end
			S_FREE_WT: begin
				mem_en   = (rdv == 34'sd1);
				mem_we   = 1'b1;
				mem_addr = fa_c - 34'sd3;
			end
			S_RD: begin
				mem_en   = (ph_q != 2'd3);
				mem_addr = rd_base - 34'sd2 + shma_pkg::calc_t'({1'b0, ph_q});
			end
			S_WR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = wl_addr;
				mem_wdata = wl_data;
			end
			default: ;
		endcase
	end

	shma_ram #(.DEPTH(MEM_WORDS), .AW(AW)) u_ram (
		.clk  (clk),
		.en   (mem_en && mem_ok),
		.we   (mem_we),
		.addr (mem_addr[AW-1:0]),
		.wdata(mem_wdata),
		.rdata(ram_rdata)
	);

	// Flag reads that fall outside the store; they return zero
	always_ff @(posedge clk) begin
		oor_q <= !mem_ok;
	end

	assign req.ready = (state_q == S_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			sp_q    <= PW'(MEM_WORDS);
			ht_q    <= PW'(shma_pkg::ROOT_LINK);
			ph_q    <= '0;
			list_q  <= L_MOVE;
			wstep_q <= '0;
			pass_q  <= 1'b0;
			first_q <= 1'b0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 2'd1;
					if (init_q == 2'd2) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						func_q  <= req.func;
						pv_q    <= req.push_value;
						need_q  <= req.alloc_words;
						fa_q    <= req.free_address;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_word_q <= '0;
					res_addr_q <= '0;
					case (func_q)
						shma_pkg::FUNC_PUSH: begin
							state_q <= S_DONE;
							if (sp_q > ht_q + PW'(1)) begin
								sp_q      <= sp_q - PW'(1);
								res_err_q <= shma_pkg::ERR_OK;
							end else begin
								res_err_q <= shma_pkg::ERR_STK_FULL;
							end
						end
						shma_pkg::FUNC_POP, shma_pkg::FUNC_PEEK: begin
							if (sp_q < PW'(MEM_WORDS) && sp_q > ht_q) begin
								res_err_q <= shma_pkg::ERR_OK;
								state_q   <= S_POP_WT;
							end else begin
								res_err_q <= shma_pkg::ERR_STK_EMPTY;
								state_q   <= S_DONE;
							end
						end
						shma_pkg::FUNC_ALLOC: begin
							if (need_q == '0) begin
								res_err_q <= shma_pkg::ERR_BAD_COUNT;
								state_q   <= S_DONE;
							end else begin
								res_err_q <= shma_pkg::ERR_OK;
								pass_q    <= 1'b0;
								first_q   <= 1'b1;
								n_q       <= '0;
								ph_q      <= '0;
								state_q   <= S_RD;
							end
						end
						shma_pkg::FUNC_FREE: begin
							if (fa_c >= 34'sd3 && fa_c < ht_c) begin
								res_err_q <= shma_pkg::ERR_OK;
								state_q   <= S_FREE_WT;
							end else begin
								res_err_q <= shma_pkg::ERR_BAD_FREE;
								state_q   <= S_DONE;
							end
						end
						default: begin
							res_err_q <= shma_pkg::ERR_OK;
							state_q   <= S_DONE;
						end
					endcase
				end
				S_POP_WT: begin
					res_word_q <= rdv[shma_pkg::WORD_W-1:0];
					if (func_q == shma_pkg::FUNC_POP) begin
						sp_q <= sp_q + PW'(1);
					end
					state_q <= S_DONE;
				end
				S_FREE_WT: begin
					if (rdv != 34'sd1) begin
						res_err_q <= shma_pkg::ERR_BAD_FREE;
					end
					state_q <= S_DONE;
				end
				S_RD: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd1) begin
						u2_q <= rdv;
					end
					if (ph_q == 2'd2) begin
						s2_q <= rdv;
					end
					if (ph_q == 2'd3) begin
						l2_q <= rdv;
						if (first_q) begin
							cur_q   <= shma_pkg::calc_t'(shma_pkg::ROOT_LINK);
							used_q  <= u2_q;
							sz_q    <= s2_q;
							lnk_q   <= rdv;
							first_q <= 1'b0;
							state_q <= S_EVAL;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				S_EVAL: begin
					if (n_q == NW'(LIMIT)) begin
						res_err_q <= shma_pkg::ERR_HEAP_FULL;
						state_q   <= S_DONE;
					end else if (brk) begin
						if (!pass_q) begin
							if (app_bad) begin
								res_err_q <= shma_pkg::ERR_HEAP_FULL;
								state_q   <= S_DONE;
							end else begin
								pass_q  <= 1'b1;
								first_q <= 1'b1;
								n_q     <= '0;
								ph_q    <= '0;
								state_q <= S_RD;
							end
						end else begin
							list_q  <= L_END;
							wstep_q <= '0;
							state_q <= S_WR;
						end
					end else begin
						ph_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_STEP: begin
					if (used_q == 34'sd0 && u2_q == 34'sd0) begin
						// merge the next free block into the current one
						sz_q    <= sz_q + s2_q + 34'sd3;
						lnk_q   <= l2_q;
						n_q     <= n_q + NW'(1);
						state_q <= S_EVAL;
					end else if (pass_q) begin
						list_q  <= L_MOVE;
						wstep_q <= '0;
						state_q <= S_WR;
					end else begin
						cur_q   <= lnk_q;
						used_q  <= u2_q;
						sz_q    <= s2_q;
						lnk_q   <= l2_q;
						n_q     <= n_q + NW'(1);
						state_q <= S_EVAL;
					end
				end
				S_WR: begin
					if (list_last) begin
						wstep_q <= '0;
						case (list_q)
							L_MOVE: begin
								cur_q   <= lnk_q;
								used_q  <= u2_q;
								sz_q    <= s2_q;
								lnk_q   <= l2_q;
								n_q     <= n_q + NW'(1);
								state_q <= S_EVAL;
							end
							L_END: begin
								list_q <= fit ? L_FIT : L_APP;
							end
							L_FIT: begin
								res_addr_q <= shma_pkg::ADDR_W'(cur_q + 34'sd1);
								state_q    <= S_DONE;
							end
							default: begin
								ht_q       <= PW'(nb_app + 34'sd2 + need_c);
								res_addr_q <= shma_pkg::ADDR_W'(nb_app + 34'sd3);
								state_q    <= S_DONE;
							end
						endcase
					end else begin
						wstep_q <= wstep_q + 3'd1;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_word_q  <= res_word_q;
			out_addr_q  <= res_addr_q;
			out_depth_q <= shma_pkg::DEPTH_W'(PW'(MEM_WORDS) - sp_q);
			out_err_q   <= res_err_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_word     = out_word_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.stack_depth   = out_depth_q;
	assign rsp.error_code    = out_err_q;

endmodule

// ===== src/shma_chk.sv =====
// Port-level checks for the allocator, bound to the top level.
module shma_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [shma_pkg::ADDR_W-1:0]  out_addr,
	input logic [shma_pkg::ERR_W-1:0]   out_err
);

	// Block goes busy after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready still high after a request transaction");

	// Error codes stay within the defined set
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_err <= shma_pkg::ERR_BAD_FREE)
		else $error("undefined error code");

	// A failed request reports no block address
	a_err_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err != shma_pkg::ERR_OK |-> out_addr == '0)
		else $error("block address on a failed request");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_err) && $stable(out_addr))
		else $error("stalled result changed");

endmodule

bind stack_heap_memory_allocator shma_chk u_shma_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_addr (rsp.block_address),
	.out_err  (rsp.error_code)
);

// ===== tb/shma_checker.sv =====
// Checker for the stack and heap allocator: predicts each result and compares it.
module shma_checker (
	input  logic  clk,
	input  logic  arst_n,
	shma_req_if   req,
	shma_rsp_if   rsp,
	output int    fail_count,
	output int    pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS      = shma_pkg::MEM_WORDS_DEF;
	localparam int WALK_BOUND = 2 * WORDS + 8;

	typedef struct packed {
		logic signed [shma_pkg::WORD_W-1:0] read_word;
		logic [shma_pkg::ADDR_W-1:0]        block_address;
		logic [shma_pkg::DEPTH_W-1:0]       stack_depth;
		logic [shma_pkg::ERR_W-1:0]         error_code;
	} result_t;

	// Shadow copy of the block's state
	logic [shma_pkg::WORD_W-1:0] word_mem [WORDS];
	longint            stack_ptr;
	longint            heap_end;

	result_t expected_results[$];

	function automatic longint peek_word(longint a);
		if (a < 0 || a >= WORDS) begin
			return 0;
		end
		return longint'($signed(word_mem[a]));
	endfunction

	function automatic void poke_word(longint a, longint v);
		if (a >= 0 && a < WORDS) begin
			word_mem[a] = v[shma_pkg::WORD_W-1:0];
		end
	endfunction

	function automatic bit block_fits(longint used, longint sz, longint need);
		return used == 0 && (sz == need || sz >= need + 3);
	endfunction

	// Walk the block chain, merging free neighbors; headers are written only on commit
	function automatic bit walk_chain(input longint need, input bit commit,
			output longint cur, output longint sz, output longint lnk, output longint used);
		int n;
		cur  = shma_pkg::ROOT_LINK;
		used = peek_word(0);
		sz   = peek_word(1);
		lnk  = peek_word(2);
		for (n = 0; n < WALK_BOUND; n++) begin
			if (lnk == -1 || block_fits(used, sz, need)) begin
				break;
			end
			if (used == 0 && peek_word(lnk - 2) == 0) begin
				sz  = sz + peek_word(lnk - 1) + 3;
				lnk = peek_word(lnk);
			end else begin
				if (commit) begin
					poke_word(cur - 1, sz);
					poke_word(cur, lnk);
				end
				cur  = lnk;
				used = peek_word(cur - 2);
				sz   = peek_word(cur - 1);
				lnk  = peek_word(cur);
			end
		end
		if (n >= WALK_BOUND) begin
			return 0;
		end
		if (commit) begin
			poke_word(cur - 1, sz);
			poke_word(cur, lnk);
		end
		return 1;
	endfunction

	// First-fit allocation with split or append; returns the error code
	function automatic logic [shma_pkg::ERR_W-1:0] allocate_block(input longint need,
			output longint addr);
		longint cur, sz, lnk, used, nb;
		addr = 0;
		if (need == 0) begin
			return shma_pkg::ERR_BAD_COUNT;
		end
		if (!walk_chain(need, 0, cur, sz, lnk, used)) begin
			return shma_pkg::ERR_HEAP_FULL;
		end
		if (!block_fits(used, sz, need)) begin
			if (lnk != -1) begin
				return shma_pkg::ERR_HEAP_FULL;
			end
			nb = cur + sz + 1;
			if (nb < 0 || !(nb + 2 + need < stack_ptr)) begin
				return shma_pkg::ERR_HEAP_FULL;
			end
		end
		void'(walk_chain(need, 1, cur, sz, lnk, used));
		if (block_fits(used, sz, need)) begin
			poke_word(cur - 2, 1);
			if (sz != need) begin
				nb = cur + need + 1;
				poke_word(nb, 0);
				poke_word(nb + 1, sz - need - 3);
				poke_word(cur - 1, need);
				poke_word(nb + 2, lnk);
				poke_word(cur, nb + 2);
			end
			addr = cur + 1;
			return shma_pkg::ERR_OK;
		end
		nb = cur + sz + 1;
		poke_word(nb, 1);
		poke_word(nb + 1, need);
		poke_word(cur, nb + 2);
		poke_word(nb + 2, -1);
		heap_end = nb + 2 + need;
		addr = nb + 3;
		return shma_pkg::ERR_OK;
	endfunction

	// Apply one request to the shadow state and form its result
	function automatic result_t heap_stack_step(logic [shma_pkg::FUNC_W-1:0] func,
			logic [shma_pkg::WORD_W-1:0] pv, logic [shma_pkg::COUNT_W-1:0] need,
			logic [shma_pkg::ADDR_W-1:0] fa);
		result_t r;
		longint  addr;
		bit      nonempty;
		r = '0;
		addr = 0;
		nonempty = stack_ptr < WORDS && stack_ptr > heap_end;
		case (func)
			shma_pkg::FUNC_PUSH: begin
				if (stack_ptr > heap_end + 1 && stack_ptr <= WORDS) begin
					stack_ptr--;
					word_mem[stack_ptr] = pv;
				end else begin
					r.error_code = shma_pkg::ERR_STK_FULL;
				end
			end
			shma_pkg::FUNC_POP, shma_pkg::FUNC_PEEK: begin
				if (nonempty) begin
					r.read_word = word_mem[stack_ptr];
					if (func == shma_pkg::FUNC_POP) begin
						stack_ptr++;
					end
				end else begin
					r.error_code = shma_pkg::ERR_STK_EMPTY;
				end
			end
			shma_pkg::FUNC_ALLOC: begin
				r.error_code = allocate_block(longint'(need), addr);
				if (r.error_code != shma_pkg::ERR_OK) begin
					addr = 0;
				end
			end
			shma_pkg::FUNC_FREE: begin
				if (fa >= 3 && longint'(fa) < heap_end && peek_word(longint'(fa) - 3) == 1) begin
					poke_word(longint'(fa) - 3, 0);
				end else begin
					r.error_code = shma_pkg::ERR_BAD_FREE;
				end
			end
			default: begin
			end
		endcase
		r.block_address = addr[shma_pkg::ADDR_W-1:0];
		r.stack_depth   = shma_pkg::DEPTH_W'(WORDS - stack_ptr);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending_count = expected_results.size();

	// Compare finished results, then predict newly accepted requests
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				word_mem[i] = '0;
			end
			word_mem[2] = '1;
			stack_ptr = WORDS;
			heap_end = shma_pkg::ROOT_LINK;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result count", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp.read_word !== want.read_word) begin
						report_mismatch("read_word", rsp.read_word, want.read_word);
					end
					if (rsp.block_address !== want.block_address) begin
						report_mismatch("block_address", rsp.block_address, want.block_address);
					end
					if (rsp.stack_depth !== want.stack_depth) begin
						report_mismatch("stack_depth", rsp.stack_depth, want.stack_depth);
					end
					if (rsp.error_code !== want.error_code) begin
						report_mismatch("error_code", rsp.error_code, want.error_code);
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(heap_stack_step(req.func, req.push_value,
					req.alloc_words, req.free_address));
			end
		end
	end

endmodule

// ===== tb/tb_stack_heap_memory_allocator.sv =====
// Top of the allocator testbench: clock, reset, stimulus and verdict.
module tb_stack_heap_memory_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 40000000;
	localparam int RANDOM_ITEMS = 1800;

	typedef struct {
		logic [shma_pkg::FUNC_W-1:0]  func;
		logic [shma_pkg::WORD_W-1:0]  pv;
		logic [shma_pkg::COUNT_W-1:0] words;
		logic [shma_pkg::ADDR_W-1:0]  fa;
	} request_t;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending_count;
	int   cycle_count = 0;

	shma_req_if req();
	shma_rsp_if rsp();

	stack_heap_memory_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	shma_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stall the result side in changing patterns
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			case ((cycle_count / 97) % 4)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= 1'($urandom_range(1, 0));
				2: rsp.ready <= ($urandom_range(3, 0) == 0);
				default: rsp.ready <= cycle_count[0];
			endcase
		end
	end

	// Collect granted block addresses so frees only touch written headers
	logic [shma_pkg::FUNC_W-1:0]  issued_funcs[$];
	logic [shma_pkg::ADDR_W-1:0]  granted_addrs[$];
	logic [shma_pkg::FUNC_W-1:0]  done_func;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready && issued_funcs.size() != 0) begin
				done_func = issued_funcs.pop_front();
				if (done_func == shma_pkg::FUNC_ALLOC && rsp.error_code == shma_pkg::ERR_OK) begin
					granted_addrs.push_back(rsp.block_address);
				end
			end
			if (req.valid && req.ready) begin
				issued_funcs.push_back(req.func);
			end
		end
	end

	function automatic logic [shma_pkg::ADDR_W-1:0] pick_free_address();
		int sel;
		sel = $urandom_range(9, 0);
		if (sel < 2 || granted_addrs.size() == 0) begin
			case ($urandom_range(3, 0))
				0: return '0;
				1: return shma_pkg::ADDR_W'(1);
				2: return shma_pkg::ADDR_W'(2);
				default: return '1;
			endcase
		end
		return granted_addrs[$urandom_range(granted_addrs.size() - 1, 0)];
	endfunction

	function automatic logic [shma_pkg::COUNT_W-1:0] pick_alloc_words();
		int sel;
		sel = $urandom_range(99, 0);
		if (sel < 4) return '0;
		if (sel < 7) return shma_pkg::COUNT_W'(1024);
		if (sel < 12) return shma_pkg::COUNT_W'($urandom_range(300, 30));
		return shma_pkg::COUNT_W'($urandom_range(12, 1));
	endfunction

	// Weight operations by the phase the run is in
	function automatic request_t random_request(int phase);
		request_t r;
		int sel;
		sel = $urandom_range(99, 0);
		r.pv = $urandom();
		r.words = pick_alloc_words();
		r.fa = pick_free_address();
		case (phase)
			0: r.func = (sel < 80) ? shma_pkg::FUNC_PUSH :
				(sel < 90) ? shma_pkg::FUNC_PEEK : shma_pkg::FUNC_ALLOC;
			1: r.func = (sel < 60) ? shma_pkg::FUNC_POP :
				(sel < 75) ? shma_pkg::FUNC_PEEK : shma_pkg::FUNC_FREE;
			2: r.func = (sel < 50) ? shma_pkg::FUNC_ALLOC :
				(sel < 90) ? shma_pkg::FUNC_FREE : shma_pkg::FUNC_PUSH;
			default: begin
				if (sel < 25) r.func = shma_pkg::FUNC_PUSH;
				else if (sel < 45) r.func = shma_pkg::FUNC_POP;
				else if (sel < 52) r.func = shma_pkg::FUNC_PEEK;
				else if (sel < 75) r.func = shma_pkg::FUNC_ALLOC;
				else if (sel < 97) r.func = shma_pkg::FUNC_FREE;
				else r.func = shma_pkg::FUNC_W'($urandom_range(7, 5));
			end
		endcase
		return r;
	endfunction

	// Hold valid through a burst; idle gaps and drain waits drop it
	task automatic send_request(request_t r);
		req.valid <= 1'b1;
		req.func <= r.func;
		req.push_value <= r.pv;
		req.alloc_words <= r.words;
		req.free_address <= r.fa;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic idle_gap(int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) begin
			@(posedge clk);
		end
	endtask

	request_t directed[$];
	request_t item;
	int       burst_left;

	initial begin
		req.valid = 1'b0;
		req.func = shma_pkg::FUNC_PUSH;
		req.push_value = '0;
		req.alloc_words = '0;
		req.free_address = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corners: empty stack, word extremes, bad counts, exact reuse, bad frees, unused codes
		directed.push_back('{shma_pkg::FUNC_POP,   32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_PEEK,  32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_PUSH,  32'h7fffffff, 11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_PUSH,  32'h80000000, 11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_PUSH,  32'hffffffff, 11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_PEEK,  32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_POP,   32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_POP,   32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd1,    10'd0});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd1024, 10'd0});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd8,    10'd0});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd6});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd6});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd0});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd2});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'h3ff});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd1,    10'd0});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd9});
		directed.push_back('{shma_pkg::FUNC_FREE,  32'h0,        11'd0,    10'd6});
		directed.push_back('{shma_pkg::FUNC_ALLOC, 32'h0,        11'd4,    10'd0});
		directed.push_back('{3'd5,                 32'hffffffff, 11'h7ff,  10'h3ff});
		directed.push_back('{3'd6,                 32'h0,        11'd0,    10'd0});
		directed.push_back('{3'd7,                 32'h12345678, 11'd5,    10'd5});
		foreach (directed[i]) begin
			send_request(directed[i]);
		end
		wait_drained();

		// Random part in bursts, with phases that fill and drain stack and heap
		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 450 == 225) begin
				wait_drained();
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(24, 1);
				idle_gap($urandom_range(6, 1));
			end
			item = random_request((n / 150) % 4);
			send_request(item);
			burst_left--;
		end
		wait_drained();
		repeat (50) @(posedge clk);

		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
